[rtl/assert_macros.svh]
// Assertion helpers for the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define USBETS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define USBETS_NEVER(lbl, expr, msg) \
    `USBETS_ASSERT(lbl, !(expr), msg)

`endif

[rtl/usbets_pkg.sv]
package usbets_pkg;

    localparam int NUM_ENDPOINTS = 4;
    localparam int LEN_BITS      = 16;
    localparam int EP_BITS       = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;
    // Wide enough for a length plus a packet count and a carry.
    localparam int EXT_W         = LEN_BITS + 11;

    typedef enum logic [2:0] {
        OP_OPEN        = 3'd0,
        OP_START_READ  = 3'd1,
        OP_START_WRITE = 3'd2,
        OP_OUT_DONE    = 3'd3,
        OP_IN_ACK      = 3'd4,
        OP_BUS_RESET   = 3'd5,
        OP_SETUP       = 3'd6,
        OP_SET_ADDRESS = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_NO_BUFFER   = 2'd1,
        STAT_NOT_ENABLED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_ARM_OUT  = 3'd1,
        ACT_LOAD_IN  = 3'd2,
        ACT_OUT_DONE = 3'd3,
        ACT_IN_DONE  = 3'd4,
        ACT_REARM    = 3'd5
    } action_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic load;    // capture the incoming request
        logic commit;  // update endpoint state and the result register
    } usbets_cmd_t;

endpackage

[rtl/usbets_ctrl.sv]
module usbets_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output usbets_pkg::usbets_cmd_t cmd
);
    import usbets_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the result register is free or drains now
                cmd.commit = !out_valid_reg || m_ready;
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

[rtl/usbets_datapath.sv]
module usbets_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  usbets_pkg::usbets_cmd_t cmd,
    input  logic [2:0]              operation,
    input  logic [1:0]              ep_index,
    input  logic                    dir_in,
    input  logic [9:0]              max_packet,
    input  logic [15:0]             request_len,
    input  logic                    has_buffer,
    input  logic [3:0]              packet_status,
    input  logic [9:0]              received_count,
    input  logic [6:0]              new_address,
    output usbets_pkg::status_t     status,
    output usbets_pkg::action_t     action,
    output logic [9:0]              payload_len,
    output logic [15:0]             buffer_offset,
    output logic [15:0]             completed_len,
    output logic                    set_data1,
    output logic [6:0]              device_address
);
    import usbets_pkg::*;

    localparam logic [EXT_W-1:0] LEN_MASK_X = EXT_W'({LEN_BITS{1'b1}});

    function automatic logic [LEN_BITS-1:0] sat_add(input logic [EXT_W-1:0] a,
                                                    input logic [EXT_W-1:0] b);
        logic [EXT_W-1:0] s;
        s = a + b;
        if (s > LEN_MASK_X)
        begin
            return {LEN_BITS{1'b1}};
        end
        return LEN_BITS'(s);
    endfunction

    function automatic logic [EXT_W-1:0] min_ext(input logic [EXT_W-1:0] a,
                                                 input logic [EXT_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // captured request
    op_t         op_reg;
    logic [1:0]  ep_reg;
    logic        dir_reg;
    logic [9:0]  mp_reg;
    logic [15:0] req_reg;
    logic        buf_reg;
    logic [3:0]  pst_reg;
    logic [9:0]  rc_reg;
    logic [6:0]  naddr_reg;

    // endpoint state
    logic [9:0]          in_mp_reg    [NUM_ENDPOINTS];
    logic [9:0]          out_mp_reg   [NUM_ENDPOINTS];
    logic                in_en_reg    [NUM_ENDPOINTS];
    logic                out_en_reg   [NUM_ENDPOINTS];
    logic [LEN_BITS-1:0] in_rem_reg   [NUM_ENDPOINTS];
    logic [LEN_BITS-1:0] out_rem_reg  [NUM_ENDPOINTS];
    logic [LEN_BITS-1:0] in_done_reg  [NUM_ENDPOINTS];
    logic [LEN_BITS-1:0] out_done_reg [NUM_ENDPOINTS];
    logic [3:0]          toggle_reg   [NUM_ENDPOINTS];
    logic [6:0]          bus_addr_reg;
    logic [6:0]          pend_addr_reg;
    logic                addr_pend_reg;

    // result register
    status_t     status_reg;
    action_t     action_reg;
    logic [9:0]  plen_reg;
    logic [15:0] offs_reg;
    logic [15:0] clen_reg;
    logic        d1_reg;
    logic [6:0]  addr_out_reg;

    // next values for the selected endpoint and the device globals
    logic [EP_BITS-1:0]  e;
    logic                ep_ok;
    logic [LEN_BITS-1:0] req_l;
    logic [EXT_W-1:0]    rc_x;
    logic [EXT_W-1:0]    rem_x;
    logic [EXT_W-1:0]    mps_x;
    logic [9:0]          in_mp_next;
    logic [9:0]          out_mp_next;
    logic                in_en_next;
    logic                out_en_next;
    logic [LEN_BITS-1:0] in_rem_next;
    logic [LEN_BITS-1:0] out_rem_next;
    logic [LEN_BITS-1:0] in_done_next;
    logic [LEN_BITS-1:0] out_done_next;
    logic [3:0]          toggle_next;
    logic [6:0]          bus_addr_next;
    logic [6:0]          pend_addr_next;
    logic                addr_pend_next;
    status_t             status_next;
    action_t             action_next;
    logic [9:0]          plen_next;
    logic [LEN_BITS-1:0] offs_next;
    logic [LEN_BITS-1:0] clen_next;
    logic                d1_next;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op_t'(operation);
            ep_reg    <= ep_index;
            dir_reg   <= dir_in;
            mp_reg    <= max_packet;
            req_reg   <= request_len;
            buf_reg   <= has_buffer;
            pst_reg   <= packet_status;
            rc_reg    <= received_count;
            naddr_reg <= new_address;
        end
        if (cmd.commit)
        begin
            status_reg   <= status_next;
            action_reg   <= action_next;
            plen_reg     <= plen_next;
            offs_reg     <= 16'(offs_next);
            clen_reg     <= 16'(clen_next);
            d1_reg       <= d1_next;
            addr_out_reg <= bus_addr_next;
        end
    end

    always_comb
    begin
        ep_ok = 32'(ep_reg) < NUM_ENDPOINTS;
        e     = ep_ok ? EP_BITS'(ep_reg) : '0;
        req_l = LEN_BITS'(req_reg);
        rc_x  = EXT_W'(rc_reg);
        rem_x = '0;
        mps_x = '0;

        in_mp_next     = in_mp_reg[e];
        out_mp_next    = out_mp_reg[e];
        in_en_next     = in_en_reg[e];
        out_en_next    = out_en_reg[e];
        in_rem_next    = in_rem_reg[e];
        out_rem_next   = out_rem_reg[e];
        in_done_next   = in_done_reg[e];
        out_done_next  = out_done_reg[e];
        toggle_next    = toggle_reg[e];
        bus_addr_next  = bus_addr_reg;
        pend_addr_next = pend_addr_reg;
        addr_pend_next = addr_pend_reg;

        status_next = STAT_OK;
        action_next = ACT_NONE;
        plen_next   = '0;
        offs_next   = '0;
        clen_next   = '0;
        d1_next     = 1'b0;

        case (op_reg)
            OP_OPEN:
            begin
                if (ep_ok)
                begin
                    if (dir_reg)
                    begin
                        in_mp_next = mp_reg;
                        in_en_next = 1'b1;
                    end
                    else
                    begin
                        out_mp_next = mp_reg;
                        out_en_next = 1'b1;
                    end
                end
            end
            OP_START_READ, OP_START_WRITE:
            begin
                if (!buf_reg && req_l != '0)
                begin
                    status_next = STAT_NO_BUFFER;
                end
                else if (!ep_ok || !((op_reg == OP_START_READ) ? out_en_reg[e]
                                                                 : in_en_reg[e]))
                begin
                    status_next = STAT_NOT_ENABLED;
                end
                else if (op_reg == OP_START_READ)
                begin
                    out_rem_next  = req_l;
                    out_done_next = '0;
                    plen_next     = 10'(min_ext(EXT_W'(req_l), EXT_W'(out_mp_reg[e])));
                    action_next   = ACT_ARM_OUT;
                end
                else
                begin
                    in_rem_next  = req_l;
                    in_done_next = '0;
                    plen_next    = 10'(min_ext(EXT_W'(req_l), EXT_W'(in_mp_reg[e])));
                    d1_next      = (e == '0);
                    action_next  = ACT_LOAD_IN;
                end
            end
            OP_OUT_DONE:
            begin
                rem_x = EXT_W'(out_rem_reg[e]);
                mps_x = EXT_W'(out_mp_reg[e]);
                if (!ep_ok || !out_en_reg[e])
                begin
                    status_next = STAT_NOT_ENABLED;
                end
                else if (pst_reg == toggle_reg[e])
                begin
                    // duplicate packet: rearm, count nothing
                    action_next = ACT_REARM;
                    plen_next   = out_mp_reg[e];
                end
                else
                begin
                    offs_next     = out_done_reg[e];
                    out_rem_next  = (rc_x >= rem_x) ? '0 : LEN_BITS'(rem_x - rc_x);
                    out_done_next = sat_add(EXT_W'(out_done_reg[e]), rc_x);
                    toggle_next   = pst_reg;
                    if (rc_x < mps_x || out_rem_next == '0)
                    begin
                        action_next = ACT_OUT_DONE;
                        clen_next   = out_done_next;
                    end
                    else
                    begin
                        action_next = ACT_ARM_OUT;
                        plen_next   = 10'(min_ext(EXT_W'(out_rem_next), mps_x));
                    end
                end
            end
            OP_IN_ACK:
            begin
                rem_x = EXT_W'(in_rem_reg[e]);
                mps_x = EXT_W'(in_mp_reg[e]);
                // apply a deferred set-address on the control IN ack
                if (ep_reg == 2'd0 && addr_pend_reg)
                begin
                    bus_addr_next  = pend_addr_reg;
                    addr_pend_next = 1'b0;
                end
                if (!ep_ok || !in_en_reg[e])
                begin
                    status_next = STAT_NOT_ENABLED;
                end
                else if (rem_x > mps_x)
                begin
                    in_rem_next  = LEN_BITS'(rem_x - mps_x);
                    in_done_next = sat_add(EXT_W'(in_done_reg[e]), mps_x);
                    plen_next    = 10'(min_ext(EXT_W'(in_rem_next), mps_x));
                    offs_next    = in_done_next;
                    action_next  = ACT_LOAD_IN;
                end
                else
                begin
                    in_done_next = sat_add(EXT_W'(in_done_reg[e]), rem_x);
                    in_rem_next  = '0;
                    clen_next    = in_done_next;
                    action_next  = ACT_IN_DONE;
                end
            end
            OP_BUS_RESET:
            begin
                bus_addr_next  = '0;
                pend_addr_next = '0;
            end
            OP_SETUP:
            begin
            end
            OP_SET_ADDRESS:
            begin
                if (bus_addr_reg == '0 && naddr_reg != '0)
                begin
                    pend_addr_next = naddr_reg;
                    addr_pend_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENDPOINTS; i++)
            begin
                in_mp_reg[i]    <= '0;
                out_mp_reg[i]   <= '0;
                in_en_reg[i]    <= 1'b0;
                out_en_reg[i]   <= 1'b0;
                in_rem_reg[i]   <= '0;
                out_rem_reg[i]  <= '0;
                in_done_reg[i]  <= '0;
                out_done_reg[i] <= '0;
                toggle_reg[i]   <= '0;
            end
            bus_addr_reg  <= '0;
            pend_addr_reg <= '0;
            addr_pend_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            for (int i = 0; i < NUM_ENDPOINTS; i++)
            begin
                if (EP_BITS'(i) == e)
                begin
                    in_mp_reg[i]    <= in_mp_next;
                    out_mp_reg[i]   <= out_mp_next;
                    in_en_reg[i]    <= in_en_next;
                    out_en_reg[i]   <= out_en_next;
                    in_rem_reg[i]   <= in_rem_next;
                    out_rem_reg[i]  <= out_rem_next;
                    in_done_reg[i]  <= in_done_next;
                    out_done_reg[i] <= out_done_next;
                end
                // bus reset clears the toggles of data endpoints, setup clears the control one
                if (op_reg == OP_BUS_RESET && i != 0)
                begin
                    toggle_reg[i] <= '0;
                end
                else if (op_reg == OP_SETUP && i == 0)
                begin
                    toggle_reg[i] <= '0;
                end
                else if (EP_BITS'(i) == e)
                begin
                    toggle_reg[i] <= toggle_next;
                end
            end
            bus_addr_reg  <= bus_addr_next;
            pend_addr_reg <= pend_addr_next;
            addr_pend_reg <= addr_pend_next;
        end
    end

    assign status         = status_reg;
    assign action         = action_reg;
    assign payload_len    = plen_reg;
    assign buffer_offset  = offs_reg;
    assign completed_len  = clen_reg;
    assign set_data1      = d1_reg;
    assign device_address = addr_out_reg;

endmodule

[rtl/usb_endpoint_transfer_segmenter_top.sv]
// Channel  Bus        Contents
// -------  ---------  -------------------------------------------------------
// input    s_axis_*   one endpoint request (operation in tuser, fields in tdata)
// output   m_axis_*   one result per request
//
// Each request is first captured, then used for the read-modify-write of the endpoint
// state; no new request is taken until that update is done.
// The result register lets the next request be captured while a result waits;
// the update step then holds until that result is taken.
// Reset (rst_n low, asynchronous) clears all endpoint state and the device address.
`include "assert_macros.svh"

module usb_endpoint_transfer_segmenter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] ep_index, [2] dir_in, [12:3] max_packet, [28:13] request_len,
    // [29] has_buffer, [33:30] packet_status, [43:34] received_count,
    // [50:44] new_address, [55:51] zero
    input  logic [55:0] s_axis_tdata,
    // [2:0] operation
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [4:2] action, [14:5] payload_len, [30:15] buffer_offset,
    // [46:31] completed_len, [47] set_data1, [54:48] device_address, [55] zero
    output logic [55:0] m_axis_tdata
);
    import usbets_pkg::*;

    usbets_cmd_t cmd;
    status_t     status;
    action_t     action;
    logic [9:0]  payload_len;
    logic [15:0] buffer_offset;
    logic [15:0] completed_len;
    logic        set_data1;
    logic [6:0]  device_address;

    usbets_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd)
    );

    usbets_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .operation      (s_axis_tuser),
        .ep_index       (s_axis_tdata[1:0]),
        .dir_in         (s_axis_tdata[2]),
        .max_packet     (s_axis_tdata[12:3]),
        .request_len    (s_axis_tdata[28:13]),
        .has_buffer     (s_axis_tdata[29]),
        .packet_status  (s_axis_tdata[33:30]),
        .received_count (s_axis_tdata[43:34]),
        .new_address    (s_axis_tdata[50:44]),
        .status         (status),
        .action         (action),
        .payload_len    (payload_len),
        .buffer_offset  (buffer_offset),
        .completed_len  (completed_len),
        .set_data1      (set_data1),
        .device_address (device_address)
    );

    assign m_axis_tdata = {1'b0, device_address, set_data1, completed_len,
                           buffer_offset, payload_len, action, status};

    // one request in flight: no capture right after a capture
    `USBETS_ASSERT(a_one_in_flight, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready,
                   "request captured while previous one still in work")
    // never overwrite a result that is still waiting
    `USBETS_NEVER(a_no_overwrite, cmd.commit && m_axis_tvalid && !m_axis_tready,
                  "result register overwritten before it was taken")
    // every update presents a result next cycle
    `USBETS_ASSERT(a_commit_shows, cmd.commit |=> m_axis_tvalid,
                   "update did not present a result")

endmodule

[tb/usb_endpoint_transfer_segmenter_top_tb.sv]
`timescale 1ns / 100ps

module usb_endpoint_transfer_segmenter_top_tb;

    import usbets_pkg::*;

    localparam int RANDOM_ITEMS    = 480;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 12;

    // One endpoint request as packed into s_axis_tdata, lowest field last.
    typedef struct packed {
        logic [6:0]  new_address;
        logic [9:0]  received_count;
        logic [3:0]  packet_status;
        logic        has_buffer;
        logic [15:0] request_len;
        logic [9:0]  max_packet;
        logic        dir_in;
        logic [1:0]  ep_index;
    } ep_request_t;

    // One result as packed into m_axis_tdata, lowest field last.
    typedef struct packed {
        logic [6:0]  device_address;
        logic        set_data1;
        logic [15:0] completed_len;
        logic [15:0] buffer_offset;
        logic [9:0]  payload_len;
        action_t     action;
        status_t     status;
    } ep_result_t;

    typedef struct {
        bit         known;
        ep_result_t res;
    } typed_result_t;

    typedef struct {
        op_t         op;
        ep_request_t rq;
        bit          known;
        status_t     status;
        action_t     action;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = OP_OPEN;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    usb_endpoint_transfer_segmenter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Endpoint state tracked alongside the block
    logic [9:0]  in_mps       [NUM_ENDPOINTS] = '{default: '0};
    logic [9:0]  out_mps      [NUM_ENDPOINTS] = '{default: '0};
    logic        in_open      [NUM_ENDPOINTS] = '{default: '0};
    logic        out_open     [NUM_ENDPOINTS] = '{default: '0};
    logic [15:0] in_left      [NUM_ENDPOINTS] = '{default: '0};
    logic [15:0] out_left     [NUM_ENDPOINTS] = '{default: '0};
    logic [15:0] in_sent      [NUM_ENDPOINTS] = '{default: '0};
    logic [15:0] out_got      [NUM_ENDPOINTS] = '{default: '0};
    logic [3:0]  out_last_pid [NUM_ENDPOINTS] = '{default: '0};
    logic [6:0]  cur_addr     = '0;
    logic [6:0]  queued_addr  = '0;
    logic        addr_queued  = 1'b0;

    ep_result_t    expected_results[$];
    typed_result_t typed_results[$];
    directed_row_t directed_table[$];

    int errors          = 0;
    int sent_count      = 0;
    int results_checked = 0;
    int completions     = 0;
    int rearms          = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_off_requests = 0;
    int idle_cycles     = 0;

    function automatic logic [15:0] add_clamped(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = a + b;
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [9:0] packet_size(logic [15:0] left, logic [9:0] mps);
        return (left < {6'd0, mps}) ? left[9:0] : mps;
    endfunction

    function automatic ep_result_t segment_request(op_t op, ep_request_t rq);
        ep_result_t res;
        bit         ep_ok;
        int         e;
        logic [9:0] mps;
        res = '0;
        res.status = STAT_OK;
        res.action = ACT_NONE;
        ep_ok = int'(rq.ep_index) < NUM_ENDPOINTS;
        e = ep_ok ? int'(rq.ep_index) : 0;
        case (op)
            OP_OPEN:
                if (ep_ok)
                begin
                    if (rq.dir_in)
                    begin
                        in_mps[e]  = rq.max_packet;
                        in_open[e] = 1'b1;
                    end
                    else
                    begin
                        out_mps[e]  = rq.max_packet;
                        out_open[e] = 1'b1;
                    end
                end
            OP_START_READ, OP_START_WRITE:
                // buffer check comes ahead of the enable check
                if (!rq.has_buffer && rq.request_len != 0)
                    res.status = STAT_NO_BUFFER;
                else if (!ep_ok || !(op == OP_START_READ ? out_open[e] : in_open[e]))
                    res.status = STAT_NOT_ENABLED;
                else if (op == OP_START_READ)
                begin
                    out_left[e] = rq.request_len;
                    out_got[e]  = '0;
                    res.payload_len = packet_size(rq.request_len, out_mps[e]);
                    res.action = ACT_ARM_OUT;
                end
                else
                begin
                    in_left[e] = rq.request_len;
                    in_sent[e] = '0;
                    res.payload_len = packet_size(rq.request_len, in_mps[e]);
                    res.set_data1 = (e == 0);
                    res.action = ACT_LOAD_IN;
                end
            OP_OUT_DONE:
                if (!ep_ok || !out_open[e])
                    res.status = STAT_NOT_ENABLED;
                else if (rq.packet_status == out_last_pid[e])
                begin
                    res.action = ACT_REARM;
                    res.payload_len = out_mps[e];
                end
                else
                begin
                    mps = out_mps[e];
                    res.buffer_offset = out_got[e];
                    out_left[e] = ({6'd0, rq.received_count} >= out_left[e]) ? 16'd0
                                : out_left[e] - rq.received_count;
                    out_got[e] = add_clamped(out_got[e], {6'd0, rq.received_count});
                    out_last_pid[e] = rq.packet_status;
                    if (rq.received_count < mps || out_left[e] == 0)
                    begin
                        res.action = ACT_OUT_DONE;
                        res.completed_len = out_got[e];
                    end
                    else
                    begin
                        res.action = ACT_ARM_OUT;
                        res.payload_len = packet_size(out_left[e], mps);
                    end
                end
            OP_IN_ACK:
            begin
                // the deferred address lands on an endpoint-0 IN ack
                if (rq.ep_index == 0 && addr_queued)
                begin
                    cur_addr    = queued_addr;
                    addr_queued = 1'b0;
                end
                if (!ep_ok || !in_open[e])
                    res.status = STAT_NOT_ENABLED;
                else
                begin
                    mps = in_mps[e];
                    if (in_left[e] > {6'd0, mps})
                    begin
                        in_left[e] = in_left[e] - mps;
                        in_sent[e] = add_clamped(in_sent[e], {6'd0, mps});
                        res.payload_len = packet_size(in_left[e], mps);
                        res.buffer_offset = in_sent[e];
                        res.action = ACT_LOAD_IN;
                    end
                    else
                    begin
                        in_sent[e] = add_clamped(in_sent[e], in_left[e]);
                        in_left[e] = '0;
                        res.completed_len = in_sent[e];
                        res.action = ACT_IN_DONE;
                    end
                end
            end
            OP_BUS_RESET:
            begin
                for (int i = 1; i < NUM_ENDPOINTS; i++)
                    out_last_pid[i] = '0;
                cur_addr    = '0;
                queued_addr = '0;
            end
            OP_SETUP:
                out_last_pid[0] = '0;
            default:
                if (cur_addr == 0 && rq.new_address != 0)
                begin
                    queued_addr = rq.new_address;
                    addr_queued = 1'b1;
                end
        endcase
        res.device_address = cur_addr;
        return res;
    endfunction

    function automatic ep_request_t random_fields();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[50:0];
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic add_row(input op_t op, input int ep, input bit dir, input int mps,
                           input int len, input bit with_buffer, input int pst,
                           input int rx_count, input int addr, input bit known,
                           input status_t status, input action_t action);
        directed_row_t row;
        row.op = op;
        row.rq = '0;
        row.rq.ep_index       = 2'(ep);
        row.rq.dir_in         = dir;
        row.rq.max_packet     = 10'(mps);
        row.rq.request_len    = 16'(len);
        row.rq.has_buffer     = with_buffer;
        row.rq.packet_status  = 4'(pst);
        row.rq.received_count = 10'(rx_count);
        row.rq.new_address    = 7'(addr);
        row.known  = known;
        row.status = status;
        row.action = action;
        directed_table.push_back(row);
    endtask

    // Offer one request and hold it until the block takes it; tvalid stays high.
    task automatic send_request(input op_t op, input ep_request_t rq,
                                input bit known = 1'b0, input ep_result_t typed = '0);
        typed_result_t t;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        t.known = known;
        t.res   = typed;
        typed_results.push_back(t);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'd0, rq};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_count++;
    endtask

    always @(posedge clk)
    begin : request_monitor
        ep_result_t    predicted;
        typed_result_t t;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predicted = segment_request(op_t'(s_axis_tuser), s_axis_tdata[50:0]);
            t = typed_results.pop_front();
            expected_results.push_back(t.known ? t.res : predicted);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        ep_result_t got;
        ep_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[54:0];
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, got);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", want.status, got.status);
                check_field("action", want.action, got.action);
                check_field("payload_len", want.payload_len, got.payload_len);
                check_field("buffer_offset", want.buffer_offset, got.buffer_offset);
                check_field("completed_len", want.completed_len, got.completed_len);
                check_field("set_data1", want.set_data1, got.set_data1);
                check_field("device_address", want.device_address, got.device_address);
                results_checked++;
                if (want.action == ACT_OUT_DONE || want.action == ACT_IN_DONE)
                    completions++;
                if (want.action == ACT_REARM)
                    rearms++;
            end
        end
    end

    initial
    begin : result_sink
        int hold_left;
        int served;
        hold_left = 0;
        served = 0;
        forever
        begin
            @(posedge clk);
            if (served != hold_off_requests)
            begin
                served = hold_off_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        ep_request_t   rq;
        ep_result_t    typed;
        directed_row_t row;
        int            directed_count;
        int            kind;
        int            pick;
        int            ep;
        int            mps;
        int            len;
        int            packets;
        int            random_target;
        bit            to_host;
        logic [3:0]    pst;
        logic [3:0]    last_pst [NUM_ENDPOINTS];

        foreach (last_pst[i])
            last_pst[i] = '0;

        // op, ep, dir, mps, len, buffer, status nibble, rx count, address
        add_row(OP_IN_ACK,      0, 0, 0,     0, 0,  0,    0,   0, 1, STAT_NOT_ENABLED, ACT_NONE);
        add_row(OP_OUT_DONE,    1, 0, 0,     0, 0,  5, 1023,   0, 1, STAT_NOT_ENABLED, ACT_NONE);
        add_row(OP_START_READ,  2, 0, 0,     5, 0,  0,    0,   0, 1, STAT_NO_BUFFER,   ACT_NONE);
        add_row(OP_START_WRITE, 3, 0, 0,     0, 0,  0,    0,   0, 1, STAT_NOT_ENABLED, ACT_NONE);
        add_row(OP_OPEN,        0, 1, 64,    0, 0,  0,    0,   0, 1, STAT_OK,          ACT_NONE);
        add_row(OP_OPEN,        0, 0, 64,    0, 0,  0,    0,   0, 1, STAT_OK,          ACT_NONE);
        add_row(OP_OPEN,        1, 0, 1023,  0, 0,  0,    0,   0, 1, STAT_OK,          ACT_NONE);
        add_row(OP_OPEN,        2, 1, 0,     0, 0,  0,    0,   0, 1, STAT_OK,          ACT_NONE);
        add_row(OP_OPEN,        3, 1, 1023,  0, 0,  0,    0,   0, 1, STAT_OK,          ACT_NONE);
        add_row(OP_SET_ADDRESS, 0, 0, 0,     0, 0,  0,    0,   0, 1, STAT_OK,          ACT_NONE);
        add_row(OP_SET_ADDRESS, 0, 0, 0,     0, 0,  0,    0, 127, 1, STAT_OK,          ACT_NONE);
        // control IN start, then the ack that applies the queued address
        add_row(OP_START_WRITE, 0, 0, 0,     0, 0,  0,    0,   0, 0, STAT_OK,          ACT_NONE);
        add_row(OP_IN_ACK,      0, 0, 0,     0, 0,  0,    0,   0, 0, STAT_OK,          ACT_NONE);
        add_row(OP_SET_ADDRESS, 0, 0, 0,     0, 0,  0,    0,   5, 0, STAT_OK,          ACT_NONE);
        // duplicate, full packet, then short packet
        add_row(OP_START_READ,  1, 0, 0, 65535, 1,  0,    0,   0, 0, STAT_OK,          ACT_NONE);
        add_row(OP_OUT_DONE,    1, 0, 0,     0, 0,  0,    0,   0, 0, STAT_OK,          ACT_NONE);
        add_row(OP_OUT_DONE,    1, 0, 0,     0, 0, 15, 1023,   0, 0, STAT_OK,          ACT_NONE);
        add_row(OP_OUT_DONE,    1, 0, 0,     0, 0,  1,  100,   0, 0, STAT_OK,          ACT_NONE);
        // oversized packet clamps the remaining count
        add_row(OP_START_READ,  0, 0, 0,    10, 1,  0,    0,   0, 0, STAT_OK,          ACT_NONE);
        add_row(OP_OUT_DONE,    0, 0, 0,     0, 0,  1, 1023,   0, 0, STAT_OK,          ACT_NONE);
        add_row(OP_SETUP,       0, 0, 0,     0, 0,  0,    0,   0, 0, STAT_OK,          ACT_NONE);
        // zero max packet never advances
        add_row(OP_START_WRITE, 2, 0, 0, 65535, 1,  0,    0,   0, 0, STAT_OK,          ACT_NONE);
        add_row(OP_IN_ACK,      2, 0, 0,     0, 0,  0,    0,   0, 0, STAT_OK,          ACT_NONE);
        // bus reset while an address is queued applies address zero
        add_row(OP_BUS_RESET,   0, 0, 0,     0, 0,  0,    0,   0, 0, STAT_OK,          ACT_NONE);
        add_row(OP_SET_ADDRESS, 0, 0, 0,     0, 0,  0,    0,   1, 0, STAT_OK,          ACT_NONE);
        add_row(OP_BUS_RESET,   0, 0, 0,     0, 0,  0,    0,   0, 0, STAT_OK,          ACT_NONE);
        add_row(OP_IN_ACK,      0, 0, 0,     0, 0,  0,    0,   0, 0, STAT_OK,          ACT_NONE);

        send_idle_pct = 30;
        recv_idle_pct = 52;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_table[i])
        begin
            row = directed_table[i];
            typed = '0;
            typed.status = row.status;
            typed.action = row.action;
            send_request(row.op, row.rq, row.known, typed);
        end
        directed_count = sent_count;

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 52 : 0;
            recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 30 : 0;
            // long receiver hold-off while requests keep coming
            if (phase == 0)
                hold_off_requests++;
            random_target = directed_count + (phase + 1) * RANDOM_ITEMS / 3;
            while (sent_count < random_target)
            begin
                kind = $urandom_range(0, 99);
                rq = random_fields();
                if (kind < 8)
                    send_request(op_t'($urandom_range(0, 7)), rq);
                else if (kind < 16)
                begin
                    pick = $urandom_range(0, 2);
                    if (pick == 0)
                        send_request(OP_BUS_RESET, rq);
                    else if (pick == 1)
                        send_request(OP_SETUP, rq);
                    else
                    begin
                        if ($urandom_range(0, 4) == 0)
                            rq.new_address = '0;
                        send_request(OP_SET_ADDRESS, rq);
                    end
                end
                else
                begin
                    // open, start, then the packet events of one transfer
                    ep = $urandom_range(0, NUM_ENDPOINTS - 1);
                    to_host = $urandom_range(0, 1);
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        mps = 8 << $urandom_range(0, 3);
                    else if (pick < 95)
                        mps = $urandom_range(1, 1023);
                    else if (pick < 98)
                        mps = 1023;
                    else
                        mps = 0;
                    if (mps >= 512 && $urandom_range(0, 99) < 4)
                        len = $urandom_range(0, 65535);
                    else
                        len = $urandom_range(0, 4 * mps + 2);
                    rq.ep_index   = 2'(ep);
                    rq.dir_in     = to_host;
                    rq.max_packet = 10'(mps);
                    send_request(OP_OPEN, rq);

                    rq = random_fields();
                    rq.ep_index    = 2'(ep);
                    rq.request_len = 16'(len);
                    rq.has_buffer  = ($urandom_range(0, 19) != 0);
                    send_request(to_host ? OP_START_WRITE : OP_START_READ, rq);

                    packets = (mps == 0) ? 3 : len / mps + $urandom_range(1, 2);
                    if (packets > 140)
                        packets = 140;
                    for (int k = 0; k < packets; k++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_request(op_t'($urandom_range(0, 7)), random_fields());
                        rq = random_fields();
                        rq.ep_index = 2'(ep);
                        if (to_host)
                            send_request(OP_IN_ACK, rq);
                        else
                        begin
                            // mostly a fresh toggle, sometimes a repeat of the last one
                            if ($urandom_range(0, 9) == 0)
                                pst = last_pst[ep];
                            else
                                pst = last_pst[ep] ^ 4'($urandom_range(1, 15));
                            last_pst[ep] = pst;
                            rq.packet_status = pst;
                            pick = $urandom_range(0, 99);
                            if (pick < 80)
                                rq.received_count = 10'(mps);
                            else if (pick < 92)
                                rq.received_count = 10'($urandom_range(0, mps));
                            else
                                rq.received_count = 10'($urandom_range(0, 1023));
                            send_request(OP_OUT_DONE, rq);
                        end
                    end
                end
            end
            // hold the sender until every result is back
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (expected_results.size() != 0);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d endpoint requests (%0d directed) across three pacing phases",
                 sent_count, directed_count);
        $display("Checked %0d results, %0d transfer completions, %0d duplicate rearms",
                 results_checked, completions, rearms);
        if (errors == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
